// ===== rtl/ckpf_pkg.sv =====
package ckpf_pkg;

    localparam int KMER_MAX = 32;
    localparam int LEN_W    = 6;
    localparam int WORD_W   = 2 * KMER_MAX;
    localparam int ID_W     = 31;
    localparam int SHIFT_W  = 6;

    localparam logic [LEN_W-1:0] RUN_MAX          = 6'd63;
    localparam logic [LEN_W-1:0] KLEN_RESET       = 6'd21;
    localparam logic [LEN_W-1:0] KLEN_FULL        = 6'd32;
    localparam logic [1:0]       BASE_COMPLEMENT  = 2'd3;

    // lowercase ASCII codes; uppercase maps onto them by setting bit 5
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_C    = 8'h63;
    localparam logic [7:0] CHAR_G    = 8'h67;
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef enum logic [1:0] {
        REG_KMER_LENGTH   = 2'd0,
        REG_PREFIX_LENGTH = 2'd1,
        REG_PREFIX_VALUE  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0]      base_char;
        logic [ID_W-1:0] sequence_id;
        logic            start_of_sequence;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] canonical_kmer;
        logic [ID_W-1:0]   kmer_sequence_id;
    } out_word_t;

    // settings derived from the configuration registers and held in a register
    typedef struct packed {
        logic [LEN_W-1:0]   klen;
        logic               plen_zero;
        logic [SHIFT_W-1:0] rev_shift;
        logic [SHIFT_W-1:0] pre_shift;
        logic [WORD_W-1:0]  mask;
        logic [WORD_W-1:0]  prefix_value;
    } cfg_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_code_t;

    function automatic base_code_t encode_base(logic [7:0] c);
        base_code_t r;
        logic [7:0] lc;
        lc     = c | CASE_BIT;
        r.ok   = 1'b1;
        r.code = 2'd0;
        unique case (lc)
            CHAR_A:  r.code = 2'd0;
            CHAR_C:  r.code = 2'd1;
            CHAR_G:  r.code = 2'd2;
            CHAR_T:  r.code = 2'd3;
            default: r.ok   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/canonical_kmer_prefix_filter_top.sv =====
// Canonical k-mer prefix filter.
// in_word carries one ASCII base, its sequence id and a start-of-sequence
// flag; a word is taken when in_valid is high and in_stall is low.
// out_word carries a canonical k-mer and the id of the base that completed
// it; it is taken when out_valid is high and out_stall is low. A base gives
// zero or one output word: none for non-ACGT, a short run or a prefix miss.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and writes take effect at the next edge.
// Throughput: one base per cycle while no stalled result blocks the path;
// a base goes through one input register, the rolling update and prefix
// compare, then the result register, where out_valid rises for a hit.
// When the receiver stalls, the result register holds its word; a base
// already in the input register waits there, or, if that register is
// empty, one more base is taken into it. in_stall then stays high until
// the result is taken.
// Reset clears the k-mer state, empties both registers and sets
// kmer_length 21, prefix_length 0, prefix_value 0.
module canonical_kmer_prefix_filter_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ckpf_pkg::in_word_t    in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ckpf_pkg::out_word_t   out_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    import ckpf_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    cfg_t      cfg;
    logic      fire;
    logic      accept;
    logic      hit;
    out_word_t result;

    ckpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ckpf_kmer u_kmer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_word_reg),
        .cfg    (cfg),
        .hit    (hit),
        .result (result)
    );

    // process the held base whenever the result register can take it
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // hold the incoming base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= in_word;
    end

    // load or drop the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= hit;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && hit)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // input side stalls only behind a stalled, full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without a blocked result");

    // a matching base shows up at the output on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && hit) |=> (out_valid && out_word == $past(result)))
        else $error("matched k-mer not presented");

    // a base that gives no result leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !hit) |=> !out_valid)
        else $error("spurious output word");

endmodule

// ===== rtl/ckpf_cfg.sv =====
module ckpf_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output ckpf_pkg::cfg_t        cfg
);
    import ckpf_pkg::*;

    logic [LEN_W-1:0]  kmer_length_reg, kmer_length_next;
    logic [LEN_W-1:0]  prefix_length_reg, prefix_length_next;
    logic [WORD_W-1:0] prefix_value_reg, prefix_value_next;
    cfg_t              cfg_reg, cfg_next;

    // clamp lengths and precompute shifts and mask
    function automatic cfg_t derive(logic [LEN_W-1:0] k_raw, logic [LEN_W-1:0] p_raw,
                                    logic [WORD_W-1:0] pv);
        cfg_t             d;
        logic [LEN_W-1:0] k;
        logic [LEN_W-1:0] p;
        logic [LEN_W-1:0] km1;
        logic [LEN_W-1:0] kmp;
        k = k_raw;
        if (k == '0)
            k = LEN_W'(1);
        if (k > KLEN_FULL)
            k = KLEN_FULL;
        p = (p_raw > k) ? k : p_raw;
        km1 = k - LEN_W'(1);
        kmp = k - p;
        d.klen         = k;
        d.plen_zero    = (p == '0);
        d.rev_shift    = {km1[4:0], 1'b0};
        d.pre_shift    = {kmp[4:0], 1'b0};
        d.mask         = (k == KLEN_FULL) ? '1
                         : ((WORD_W'(1) << {k, 1'b0}) - WORD_W'(1));
        d.prefix_value = pv;
        return d;
    endfunction

    assign cfg_ready = 1'b1;

    // pick up the written register
    always_comb
    begin
        kmer_length_next   = kmer_length_reg;
        prefix_length_next = prefix_length_reg;
        prefix_value_next  = prefix_value_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KMER_LENGTH:   kmer_length_next   = cfg_data[LEN_W-1:0];
                REG_PREFIX_LENGTH: prefix_length_next = cfg_data[LEN_W-1:0];
                REG_PREFIX_VALUE:  prefix_value_next  = cfg_data;
                default:           ;
            endcase
        end
        cfg_next = derive(kmer_length_next, prefix_length_next, prefix_value_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg   <= KLEN_RESET;
            prefix_length_reg <= '0;
            prefix_value_reg  <= '0;
            cfg_reg           <= derive(KLEN_RESET, '0, '0);
        end
        else
        begin
            kmer_length_reg   <= kmer_length_next;
            prefix_length_reg <= prefix_length_next;
            prefix_value_reg  <= prefix_value_next;
            cfg_reg           <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ckpf_kmer.sv =====
module ckpf_kmer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  ckpf_pkg::in_word_t    item,
    input  ckpf_pkg::cfg_t        cfg,
    output logic                  hit,
    output ckpf_pkg::out_word_t   result
);
    import ckpf_pkg::*;

    logic [WORD_W-1:0] fwd_reg, fwd_next;
    logic [WORD_W-1:0] rev_reg, rev_next;
    logic [LEN_W-1:0]  run_reg, run_next;

    logic [WORD_W-1:0] fwd_cur, rev_cur, kmer;
    logic [LEN_W-1:0]  run_cur;
    base_code_t        base;
    logic [1:0]        comp;
    logic              match;

    // roll both words by one base
    always_comb
    begin
        fwd_cur = item.start_of_sequence ? '0 : fwd_reg;
        rev_cur = item.start_of_sequence ? '0 : rev_reg;
        run_cur = item.start_of_sequence ? '0 : run_reg;
        base    = encode_base(item.base_char);
        comp    = base.code ^ BASE_COMPLEMENT;

        fwd_next = fwd_cur;
        rev_next = rev_cur;
        run_next = '0;
        if (base.ok)
        begin
            fwd_next = ((fwd_cur << 2) | WORD_W'(base.code)) & cfg.mask;
            rev_next = ((WORD_W'(comp) << cfg.rev_shift) | (rev_cur >> 2)) & cfg.mask;
            run_next = (run_cur == RUN_MAX) ? RUN_MAX : run_cur + LEN_W'(1);
        end

        kmer  = (fwd_next < rev_next) ? fwd_next : rev_next;
        match = cfg.plen_zero || (cfg.prefix_value == (kmer >> cfg.pre_shift));
        hit   = base.ok && (run_next >= cfg.klen) && match;

        result.canonical_kmer   = kmer;
        result.kmer_sequence_id = item.sequence_id;
    end

    // advance state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rev_reg <= '0;
            run_reg <= '0;
        end
        else if (fire)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            run_reg <= run_next;
        end
    end

endmodule

// ===== tb/sv/canonical_kmer_prefix_filter_top_tb.sv =====
module canonical_kmer_prefix_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckpf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int BASE_TARGET = 1500;
    localparam int HOLD_CYCLES = 300;
    localparam int PIPE_SETTLE = 6;

    localparam logic [7:0] BASE_SET [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // predictor copy of the configuration and the rolling k-mer state
    logic [LEN_W-1:0]  klen_reg = KLEN_RESET;
    logic [LEN_W-1:0]  plen_reg = '0;
    logic [WORD_W-1:0] prefix_reg = '0;
    logic [WORD_W-1:0] fwd_word = '0;
    logic [WORD_W-1:0] rc_word = '0;
    logic [LEN_W-1:0]  run_len = '0;

    out_word_t kmer_expect_q [$];

    int error_count = 0;
    int cycle_count = 0;
    int bases_sent = 0;
    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    bit hold_off_req = 1'b0;
    int hold_left = 0;
    int stall_run = 0;

    canonical_kmer_prefix_filter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // 2-bit code of a nucleotide, -1 for anything else
    function automatic int base_code(logic [7:0] c);
        case (c)
            "A", "a": return 0;
            "C", "c": return 1;
            "G", "g": return 2;
            "T", "t": return 3;
            default:  return -1;
        endcase
    endfunction

    // advance the rolling words by one base and queue the k-mer it emits, if any
    function automatic void predict_kmer(in_word_t w);
        int          klen;
        int          plen;
        int          code;
        logic [63:0] mask;
        logic [63:0] t;
        logic [63:0] kmer;
        out_word_t   exp_word;
        klen = (klen_reg == 0) ? 1 : ((klen_reg > KMER_MAX) ? KMER_MAX : int'(klen_reg));
        plen = plen_reg;
        if (plen > klen)
            plen = klen;
        mask = (klen >= KMER_MAX) ? '1 : ((64'd1 << (2 * klen)) - 64'd1);
        if (w.start_of_sequence)
        begin
            fwd_word = '0;
            rc_word  = '0;
            run_len  = '0;
        end
        code = base_code(w.base_char);
        if (code < 0)
        begin
            run_len = '0;
            return;
        end
        t = 64'(code);
        fwd_word = ((fwd_word << 2) | t) & mask;
        rc_word  = (((t ^ 64'(BASE_COMPLEMENT)) << (2 * (klen - 1))) | (rc_word >> 2)) & mask;
        if (run_len < RUN_MAX)
            run_len = run_len + 1'b1;
        if (int'(run_len) < klen)
            return;
        kmer = (fwd_word < rc_word) ? fwd_word : rc_word;
        if (plen != 0 && prefix_reg != (kmer >> (2 * (klen - plen))))
            return;
        exp_word.canonical_kmer   = kmer;
        exp_word.kmer_sequence_id = w.sequence_id;
        kmer_expect_q.insert(kmer_expect_q.size(), exp_word);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // mostly nucleotides in mixed case, now and then any byte
    function automatic logic [7:0] pick_base();
        if ($urandom_range(0, 99) < 8)
            return 8'($urandom);
        return BASE_SET[$urandom_range(0, 7)];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // offer one word, hold it until taken, then idle for a random gap
    task automatic send_base(logic [7:0] c, logic [ID_W-1:0] id, bit sos);
        in_word_t w;
        int       gap;
        w.base_char         = c;
        w.sequence_id       = id;
        w.start_of_sequence = sos;
        gap = pick_gap();
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_kmer(w);
        bases_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_KMER_LENGTH:   klen_reg   = data[LEN_W-1:0];
            REG_PREFIX_LENGTH: plen_reg   = data[LEN_W-1:0];
            REG_PREFIX_VALUE:  prefix_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_filter(int klen, int plen, logic [63:0] pval);
        write_reg(REG_KMER_LENGTH, 64'(klen));
        write_reg(REG_PREFIX_LENGTH, 64'(plen));
        write_reg(REG_PREFIX_VALUE, pval);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every expected k-mer, then let the pipe empty
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (kmer_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // every letter in both cases, non-nucleotides, id extremes, length 1
    task automatic test_base_encoding();
        set_filter(1, 0, '0);
        send_base("A", '0, 1'b1);
        send_base("C", 31'($urandom), 1'b0);
        send_base("G", 31'($urandom), 1'b0);
        send_base("T", 31'($urandom), 1'b0);
        send_base("a", 31'($urandom), 1'b0);
        send_base("N", 31'($urandom), 1'b0);
        send_base("c", 31'($urandom), 1'b0);
        send_base(8'h00, 31'($urandom), 1'b0);
        send_base("g", 31'($urandom), 1'b0);
        send_base(8'hFF, '1, 1'b1);
        send_base("t", '1, 1'b0);
        send_base("T", 31'($urandom), 1'b1);
    endtask

    // exact prefix hit and miss, then a prefix longer than the k-mer
    task automatic test_prefix_match();
        settle_idle();
        set_filter(2, 2, 64'd1);
        send_base("A", 31'($urandom), 1'b1);
        send_base("C", 31'($urandom), 1'b0);
        send_base("G", 31'($urandom), 1'b0);
        send_base("c", 31'($urandom), 1'b0);
        settle_idle();
        set_filter(2, 5, 64'd6);
        send_base("C", 31'($urandom), 1'b1);
        send_base("G", 31'($urandom), 1'b0);
        send_base("t", 31'($urandom), 1'b0);
        send_base("a", 31'($urandom), 1'b0);
    endtask

    // hold the receiver off while bases keep coming so the block backs up
    task automatic test_backpressure();
        logic [ID_W-1:0] id;
        settle_idle();
        set_filter(3, 0, '0);
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        id = 31'($urandom);
        for (int i = 0; i < 48; i++)
            send_base(BASE_SET[$urandom_range(0, 7)], id, i == 0);
        gaps_on = 1'b1;
    endtask

    // phases of random settings, each followed by sequences of random bases
    task automatic test_random_phases();
        int              phase;
        int              klen;
        int              plen;
        int              r;
        int              seq_len;
        int              left;
        logic [63:0]     pval;
        logic [ID_W-1:0] id;
        bit              sos;
        phase = 0;
        while (bases_sent < BASE_TARGET)
        begin
            settle_idle();
            case (phase)
                0:       klen = KMER_MAX;
                1:       klen = 1;
                default: klen = ($urandom_range(0, 4) == 0) ? KMER_MAX : $urandom_range(1, 32);
            endcase
            r = (phase == 0) ? 0 : $urandom_range(0, 9);
            if (r < 3)
            begin
                plen = 0;
                pval = {$urandom, $urandom};
            end
            else if (r < 8)
            begin
                plen = $urandom_range(1, 3);
                pval = 64'($urandom_range(0, (1 << (2 * plen)) - 1));
            end
            else
            begin
                plen = $urandom_range(0, 32);
                pval = {$urandom, $urandom};
            end
            set_filter(klen, plen, pval);
            gaps_on   = (phase != 2) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != 2) && ($urandom_range(0, 3) != 0);
            left = (phase == 0) ? 300 : $urandom_range(80, 200);
            while (left > 0)
            begin
                if (phase == 0 || $urandom_range(0, 9) == 0)
                    seq_len = $urandom_range(64, 110);
                else
                    seq_len = $urandom_range(1, 40);
                id  = 31'($urandom);
                sos = ($urandom_range(0, 7) != 0);
                for (int i = 0; i < seq_len && left > 0; i++)
                begin
                    send_base(pick_base(), id, sos && i == 0);
                    left--;
                end
            end
            phase++;
        end
    endtask

    // drive the receiver stall: forced hold-off, random runs, or none
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!stalls_on)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run > 0)
            stall_run--;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 3);
        end
    end

    // compare each taken word with the oldest expected k-mer
    always @(posedge clk)
    begin
        out_word_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (kmer_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected k-mer %h id %h",
                                          out_word.canonical_kmer, out_word.kmer_sequence_id));
            else
            begin
                exp_word = kmer_expect_q.pop_front();
                if (out_word.canonical_kmer !== exp_word.canonical_kmer)
                    report_mismatch($sformatf("canonical_kmer %h, expected %h",
                                              out_word.canonical_kmer, exp_word.canonical_kmer));
                if (out_word.kmer_sequence_id !== exp_word.kmer_sequence_id)
                    report_mismatch($sformatf("kmer_sequence_id %h, expected %h",
                                              out_word.kmer_sequence_id,
                                              exp_word.kmer_sequence_id));
            end
        end
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_base_encoding();
        test_prefix_match();
        test_backpressure();
        test_random_phases();
        settle_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
